/* rtl/stp_pkg.sv */
// Shared constants, codes and the coil phase table for the stepper ramp driver.
package stp_pkg;

    localparam int unsigned DIV_WIDTH     = 32;
    localparam int unsigned CFG_WIDTH     = 32;
    localparam int unsigned CFG_IDX_WIDTH = 2;
    localparam int unsigned TARGET_WIDTH  = 17;
    localparam int unsigned OUT_RATE_W    = 17;
    localparam int unsigned RELOAD_WIDTH  = 31;
    localparam int unsigned COIL_WIDTH    = 4;
    localparam int unsigned S_TDATA_W     = 24;
    localparam int unsigned M_TDATA_W     = 56;
    localparam int unsigned M_TUSER_W     = 3;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_TARGET = 1'b1;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_ACC_LIMIT = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CLOCK_HZ  = 2'd1;

    localparam logic [CFG_WIDTH-1:0] ACC_LIMIT_RESET = 32'd10000;
    localparam logic [CFG_WIDTH-1:0] CLOCK_HZ_RESET  = 32'd50000000;

    typedef logic [1:0] phase_t;
    typedef logic [COIL_WIDTH-1:0] coil_t;

    // Full-step drive pattern, bits 3..0 = A1, A2, B1, B2.
    function automatic coil_t coil_lookup(input phase_t ph);
        coil_t pat;
        case (ph)
            2'd0:    pat = 4'hA;
            2'd1:    pat = 4'h9;
            2'd2:    pat = 4'h5;
            2'd3:    pat = 4'h6;
            default: pat = 4'hA;
        endcase
        return pat;
    endfunction

endpackage

/* rtl/stp_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle, shared by the ramp sequencer.
module stp_div #(
    parameter int unsigned DSR_WIDTH = 18
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [stp_pkg::DIV_WIDTH-1:0] dividend,
    input  logic [DSR_WIDTH-1:0]          divisor,
    output logic                          done,
    output logic [stp_pkg::DIV_WIDTH-1:0] quotient
);
    import stp_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_WIDTH);

    logic [DIV_WIDTH-1:0] quo_reg, quo_next;
    logic [DSR_WIDTH-1:0] rem_reg, rem_next;
    logic [DSR_WIDTH-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DSR_WIDTH:0]   trial;
    logic [DSR_WIDTH:0]   diff;

    assign trial = {rem_reg, quo_reg[DIV_WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // keep the partial remainder when the trial subtraction underflows
            if (!diff[DSR_WIDTH]) begin
                rem_next = diff[DSR_WIDTH-1:0];
                quo_next = {quo_reg[DIV_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = trial[DSR_WIDTH-1:0];
                quo_next = {quo_reg[DIV_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/stepper_phase_ramp_driver.sv */
// Top level: full-step stepper driver with acceleration-limited rate ramp.
//
// Input stream (s_): s_tuser is the command (0 = step tick, 1 = new target),
// s_tdata carries the signed target rate. Every accepted word yields exactly one
// result word on the m_ stream: coil pattern for a tick, plus the ramped rate,
// direction and, when the rate moved toward its goal, a timer reload value
// (clock_hz / (2*|rate|)) or a stop flag at rate zero.
// Config port: cfg_we writes cfg_data into register cfg_index
// (0 = acc_limit, 1 = clock_hz); other indexes are ignored. Write only while idle.
// Timing: one word at a time. A word whose rate is already at its goal goes
// straight to the result; a ramp step from zero makes one pass through the
// shared radix-2 divider (reload), and a ramp step from a nonzero rate makes
// two (limit, then reload). No reload pass is made when the new rate is zero.
// The result sits in an output register, so the next word is accepted while it
// waits; if m_tready stays low, the sequencer holds its finished word until the
// output register frees up, and s_tready stays low meanwhile.
// Reset (aresetn low, synchronous): rate and goal zero, phase 0, direction
// forward, acc_limit 10000, clock_hz 50000000, output stream empty.
module stepper_phase_ramp_driver #(
    parameter int unsigned RATE_WIDTH = 17
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [stp_pkg::S_TDATA_W-1:0]      s_tdata,   // [16:0] target_rate
    input  logic                               s_tuser,   // [0] command
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [3:0] coil_pattern, [34:4] reload_value, [51:35] current_rate, [52] direction
    output logic [stp_pkg::M_TDATA_W-1:0]      m_tdata,
    // [0] coil_valid, [1] reload_valid, [2] stopped
    output logic [stp_pkg::M_TUSER_W-1:0]      m_tuser,
    input  logic                               cfg_we,
    input  logic [stp_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [stp_pkg::CFG_WIDTH-1:0]      cfg_data
);
    import stp_pkg::*;

    localparam int unsigned RW = RATE_WIDTH;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_LIM    = 3'd2;
    localparam logic [2:0] ST_APPLY  = 3'd3;
    localparam logic [2:0] ST_CHK    = 3'd4;
    localparam logic [2:0] ST_RELOAD = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]                state_reg, state_next;
    logic [CFG_WIDTH-1:0]      acc_reg, acc_next;
    logic [CFG_WIDTH-1:0]      clk_reg, clk_next;
    phase_t                    phase_reg, phase_next;
    logic signed [RW-1:0]      rate_reg, rate_next;
    logic signed [RW-1:0]      goal_reg, goal_next;
    logic                      fwd_reg, fwd_next;
    logic [RW-1:0]             delta_reg, delta_next;
    logic                      down_reg, down_next;
    logic                      nolim_reg, nolim_next;
    logic                      coil_v_reg, coil_v_next;
    coil_t                     coil_reg, coil_next;
    logic                      rld_v_reg, rld_v_next;
    logic [RELOAD_WIDTH-1:0]   rld_reg, rld_next;
    logic                      stop_reg, stop_next;
    logic                      m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]      m_data_reg, m_data_next;
    logic [M_TUSER_W-1:0]      m_user_reg, m_user_next;

    logic signed [TARGET_WIDTH-1:0] s_target;
    logic signed [RW:0]        rate_x;
    logic signed [RW:0]        goal_x;
    logic signed [RW:0]        diff;
    logic [RW:0]               diff_mag;
    logic [RW:0]               rate_mag;
    logic [RW:0]               div_dsr;
    logic signed [32:0]        rate_out_x;
    logic [RW-1:0]             step;
    logic                      div_start;
    logic [DIV_WIDTH-1:0]      div_dvd;
    logic                      div_done;
    logic [DIV_WIDTH-1:0]      div_quo;
    logic                      out_free;

    assign s_target   = s_tdata[TARGET_WIDTH-1:0];
    assign rate_x     = (RW+1)'(rate_reg);
    assign goal_x     = (RW+1)'(goal_reg);
    assign diff       = goal_x - rate_x;
    assign diff_mag   = diff[RW] ? (RW+1)'(-diff) : diff;
    assign rate_mag   = rate_x[RW] ? (RW+1)'(-rate_x) : rate_x;
    // twice the rate magnitude; |rate| never exceeds 2^(RW-1)
    assign div_dsr    = {rate_mag[RW-1:0], 1'b0};
    assign rate_out_x = 33'(rate_reg);
    assign out_free   = !m_valid_reg || m_tready;

    // clamp the ramp step to the acceleration limit unless starting from zero
    assign step = (nolim_reg || (DIV_WIDTH'(delta_reg) <= div_quo)) ? delta_reg
                                                                   : div_quo[RW-1:0];

    stp_div #(
        .DSR_WIDTH(RW + 1)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        clk_next     = clk_reg;
        phase_next   = phase_reg;
        rate_next    = rate_reg;
        goal_next    = goal_reg;
        fwd_next     = fwd_reg;
        delta_next   = delta_reg;
        down_next    = down_reg;
        nolim_next   = nolim_reg;
        coil_v_next  = coil_v_reg;
        coil_next    = coil_reg;
        rld_v_next   = rld_v_reg;
        rld_next     = rld_reg;
        stop_next    = stop_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        div_start    = 1'b0;
        div_dvd      = acc_reg;

        if (cfg_we) begin
            case (cfg_index)
                REG_ACC_LIMIT: acc_next = cfg_data;
                REG_CLOCK_HZ:  clk_next = cfg_data;
                default:       ;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    rld_v_next = 1'b0;
                    rld_next   = '0;
                    stop_next  = 1'b0;
                    if (s_tuser == CMD_TICK) begin
                        coil_v_next = 1'b1;
                        coil_next   = coil_lookup(phase_reg);
                        phase_next  = phase_reg + (fwd_reg ? 2'd1 : 2'd3);
                    end else begin
                        coil_v_next = 1'b0;
                        coil_next   = '0;
                        goal_next   = RW'(33'(s_target));
                    end
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                delta_next = diff_mag[RW-1:0];
                down_next  = diff[RW];
                nolim_next = (rate_reg == '0);
                if (rate_reg == goal_reg) begin
                    state_next = ST_DONE;
                end else if (rate_reg == '0) begin
                    state_next = ST_APPLY;
                end else begin
                    div_start  = 1'b1;
                    div_dvd    = acc_reg;
                    state_next = ST_LIM;
                end
            end
            ST_LIM: begin
                if (div_done) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                rate_next  = down_reg ? RW'(rate_reg - step) : RW'(rate_reg + step);
                rld_v_next = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                fwd_next = !rate_reg[RW-1];
                if (rate_reg == '0) begin
                    stop_next  = 1'b1;
                    rld_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    div_dvd    = clk_reg;
                    state_next = ST_RELOAD;
                end
            end
            ST_RELOAD: begin
                if (div_done) begin
                    rld_next   = div_quo[RELOAD_WIDTH-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the finished word until the output register frees up
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, fwd_reg, rate_out_x[OUT_RATE_W-1:0],
                                    rld_reg, coil_reg};
                    m_user_next  = {stop_reg, rld_v_reg, coil_v_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= ACC_LIMIT_RESET;
            clk_reg     <= CLOCK_HZ_RESET;
            phase_reg   <= '0;
            rate_reg    <= '0;
            goal_reg    <= '0;
            fwd_reg     <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            clk_reg     <= clk_next;
            phase_reg   <= phase_next;
            rate_reg    <= rate_next;
            goal_reg    <= goal_next;
            fwd_reg     <= fwd_next;
            m_valid_reg <= m_valid_next;
        end
        delta_reg  <= delta_next;
        down_reg   <= down_next;
        nolim_reg  <= nolim_next;
        coil_v_reg <= coil_v_next;
        coil_reg   <= coil_next;
        rld_v_reg  <= rld_v_next;
        rld_reg    <= rld_next;
        stop_reg   <= stop_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* bench/stepper_phase_ramp_driver_tb.sv */
// Self-checking bench for the full-step stepper driver with acceleration-limited ramp.
`timescale 1ns / 100ps

module stepper_phase_ramp_driver_tb;
    import stp_pkg::*;

    localparam int unsigned RATE_W = 17;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int QUIET_CYCLES = 8;
    localparam int TAIL_CYCLES  = 100;
    localparam int HOLD_CYCLES  = 600;

    // Indexes past the two real registers; the block must ignore them.
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_B = 2'd3;

    // Phase 3..0 drive patterns, A1 A2 B1 B2 in each nibble.
    localparam logic [15:0] COIL_SEQ = {4'h6, 4'h5, 4'h9, 4'hA};

    typedef struct packed {
        logic                    coil_valid;
        coil_t                   coil_pattern;
        logic                    reload_valid;
        logic [RELOAD_WIDTH-1:0] reload_value;
        logic                    stopped;
        logic [OUT_RATE_W-1:0]   rate;
        logic                    direction;
    } drive_result_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_W-1:0]     s_tdata;   // [16:0] target_rate
    logic                     s_tuser;   // [0] command
    logic                     m_tvalid;
    logic                     m_tready;
    // [3:0] coil_pattern, [34:4] reload_value, [51:35] current_rate, [52] direction
    logic [M_TDATA_W-1:0]     m_tdata;
    // [0] coil_valid, [1] reload_valid, [2] stopped
    logic [M_TUSER_W-1:0]     m_tuser;
    logic                     cfg_we;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]     cfg_data;

    // Predicted motor state and register copies.
    phase_t                   motor_phase = 2'd0;
    logic signed [RATE_W-1:0] motor_rate  = '0;
    logic signed [RATE_W-1:0] motor_goal  = '0;
    logic                     motor_fwd   = 1'b1;
    logic [CFG_WIDTH-1:0]     acc_limit_q = ACC_LIMIT_RESET;
    logic [CFG_WIDTH-1:0]     clock_hz_q  = CLOCK_HZ_RESET;

    drive_result_t pending_drive[$];

    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    int hold_request = 0;
    int cycle_count  = 0;
    int mismatches   = 0;
    int words_sent   = 0;
    int words_seen   = 0;
    int ticks_seen   = 0;
    int reloads_seen = 0;
    int stops_seen   = 0;
    int settings_run = 1;

    stepper_phase_ramp_driver #(.RATE_WIDTH(RATE_W)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // One tick or target word: phase advance, then one ramp step.
    function automatic drive_result_t step_drive(input logic cmd,
                                                 input logic [TARGET_WIDTH-1:0] tgt);
        drive_result_t r;
        longint now_l, goal_l, gap, cap, mag_l, acc_l, clk_l, quot;
        r = '0;
        if (cmd == CMD_TICK) begin
            r.coil_valid   = 1'b1;
            r.coil_pattern = COIL_SEQ[{motor_phase, 2'b00} +: 4];
            motor_phase    = motor_fwd ? motor_phase + 2'd1 : motor_phase - 2'd1;
        end else begin
            motor_goal = tgt;
        end
        now_l  = motor_rate;
        goal_l = motor_goal;
        acc_l  = acc_limit_q;
        clk_l  = clock_hz_q;
        if (now_l != goal_l) begin
            gap = (goal_l > now_l) ? goal_l - now_l : now_l - goal_l;
            if (now_l != 0) begin
                mag_l = (now_l < 0) ? -now_l : now_l;
                cap = acc_l / (2 * mag_l);
                if (cap < gap)
                    gap = cap;
            end
            now_l = (goal_l < now_l) ? now_l - gap : now_l + gap;
            motor_rate = now_l[RATE_W-1:0];
            motor_fwd  = (motor_rate >= 0);
            r.reload_valid = 1'b1;
            if (motor_rate == 0) begin
                r.stopped = 1'b1;
            end else begin
                now_l = motor_rate;
                mag_l = (now_l < 0) ? -now_l : now_l;
                quot  = clk_l / (2 * mag_l);
                r.reload_value = quot[RELOAD_WIDTH-1:0];
            end
        end
        r.rate      = motor_rate;
        r.direction = motor_fwd;
        return r;
    endfunction

    function automatic logic [TARGET_WIDTH-1:0] rand_target();
        return TARGET_WIDTH'($urandom);
    endfunction

    // Mix of full-range, slow, medium, edge-of-range and zero targets.
    function automatic logic [TARGET_WIDTH-1:0] pick_target();
        int v;
        case ($urandom_range(0, 5))
            0, 5: v = $urandom_range(0, 131071);
            1:    v = int'($urandom_range(0, 1000)) - 500;
            2:    v = int'($urandom_range(0, 40000)) - 20000;
            3: begin
                case ($urandom_range(0, 3))
                    0:       v = 65535;
                    1:       v = -65536;
                    2:       v = 1;
                    default: v = -1;
                endcase
            end
            default: v = 0;
        endcase
        return v[TARGET_WIDTH-1:0];
    endfunction

    task automatic send_word(input logic cmd, input logic [TARGET_WIDTH-1:0] tgt);
        int gap_len;
        if (send_idle_on && $urandom_range(0, 5) == 0) begin
            gap_len = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap_len) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W-TARGET_WIDTH){1'b0}}, tgt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_drive.push_back(step_drive(cmd, tgt));
        words_sent++;
    endtask

    // Drop valid and hold until every outstanding result is back.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_drive.size() != 0) @(posedge aclk);
    endtask

    task automatic settle();
        pause_until_drained();
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == REG_ACC_LIMIT)
            acc_limit_q = value;
        else if (idx == REG_CLOCK_HZ)
            clock_hz_q = value;
    endtask

    task automatic set_registers(input logic [CFG_WIDTH-1:0] acc,
                                 input logic [CFG_WIDTH-1:0] clk);
        settle();
        write_reg(REG_ACC_LIMIT, acc);
        write_reg(REG_CLOCK_HZ, clk);
        settings_run++;
    endtask

    // Mostly target-then-ticks sequences, some loose words and drain pauses.
    task automatic run_ramp_traffic(input int n_words);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 4) == 0) begin
                send_word(1'($urandom_range(0, 1)), rand_target());
                sent++;
            end else begin
                send_word(CMD_TARGET, pick_target());
                burst = $urandom_range(1, 24);
                repeat (burst) send_word(CMD_TICK, rand_target());
                sent += burst + 1;
            end
            if ($urandom_range(0, 39) == 0)
                pause_until_drained();
        end
    endtask

    task automatic test_reset_values();
        send_word(CMD_TICK, '0);              // at goal: coil only
        send_word(CMD_TICK, 17'h1FFFF);
        send_word(CMD_TARGET, 17'h00000);     // target equal to rate
        send_word(CMD_TARGET, 17'h0FFFF);     // jump from zero
        send_word(CMD_TICK, '0);              // at goal again: coil only
        send_word(CMD_TARGET, 17'h10000);
        settle();
        write_reg(REG_SPARE_A, '0);
        write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
    endtask

    task automatic test_register_extremes();
        set_registers(32'hFFFF_FFFF, 32'd1);
        write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_B, '0);
        repeat (3) send_word(CMD_TICK, rand_target());
        send_word(CMD_TARGET, 17'h10000);
        repeat (3) send_word(CMD_TICK, rand_target());
        set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_TARGET, 17'h00001);
        send_word(CMD_TICK, '0);
        send_word(CMD_TARGET, 17'h00000);     // ramp to stop
        send_word(CMD_TICK, '0);
        send_word(CMD_TARGET, 17'h1FFFF);
        repeat (3) send_word(CMD_TICK, '0);   // reverse stepping
        settle();
    endtask

    task automatic test_random_ramps();
        logic [CFG_WIDTH-1:0] clk;
        set_registers(ACC_LIMIT_RESET, CLOCK_HZ_RESET);
        run_ramp_traffic(290);
        set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_ramp_traffic(290);
        set_registers(32'd0, 32'd1);
        run_ramp_traffic(290);
        clk = $urandom;
        if (clk == 0)
            clk = 1;
        set_registers($urandom, clk);
        run_ramp_traffic(290);
        set_registers($urandom_range(100000, 400000000), $urandom_range(1, 32'hFFFF_FFFF));
        run_ramp_traffic(290);
        settle();
    endtask

    task automatic test_output_backpressure();
        set_registers($urandom_range(1000000, 32'hFFFF_FFFF), CLOCK_HZ_RESET);
        send_idle_on = 1'b0;
        hold_request = HOLD_CYCLES;
        run_ramp_traffic(40);
        send_idle_on = 1'b1;
        settle();
    endtask

    task automatic test_sender_pauses();
        repeat (6) begin
            run_ramp_traffic(12);
            pause_until_drained();
        end
        settle();
    endtask

    task automatic test_steady_stream();
        set_registers($urandom_range(200000, 32'hFFFF_FFFF), $urandom_range(1, 32'hFFFF_FFFF));
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        run_ramp_traffic(260);
        settle();
    endtask

    // Receiver: random stall bursts plus one long requested hold-off.
    initial begin
        int n;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 18);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        drive_result_t got;
        drive_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.coil_pattern = m_tdata[3:0];
            got.reload_value = m_tdata[34:4];
            got.rate         = m_tdata[51:35];
            got.direction    = m_tdata[52];
            got.coil_valid   = m_tuser[0];
            got.reload_valid = m_tuser[1];
            got.stopped      = m_tuser[2];
            words_seen++;
            ticks_seen   += got.coil_valid;
            reloads_seen += got.reload_valid;
            stops_seen   += got.stopped;
            if (pending_drive.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word at cycle %0d", cycle_count);
            end else begin
                want = pending_drive.pop_front();
                if (got.coil_valid !== want.coil_valid ||
                    got.coil_pattern !== want.coil_pattern ||
                    got.reload_valid !== want.reload_valid ||
                    got.reload_value !== want.reload_value ||
                    got.stopped !== want.stopped ||
                    got.rate !== want.rate ||
                    got.direction !== want.direction) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch word %0d at cycle %0d", words_seen, cycle_count);
                        $display("  exp coil %0b/%h reload %0b/%0d stop %0b rate %0d dir %0b",
                                 want.coil_valid, want.coil_pattern,
                                 want.reload_valid, want.reload_value, want.stopped,
                                 $signed(want.rate), want.direction);
                        $display("  got coil %0b/%h reload %0b/%0d stop %0b rate %0d dir %0b",
                                 got.coil_valid, got.coil_pattern, got.reload_valid,
                                 got.reload_value, got.stopped, $signed(got.rate),
                                 got.direction);
                    end
                end
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_register_extremes();
        test_random_ramps();
        test_output_backpressure();
        test_sender_pauses();
        test_steady_stream();

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run: %0d words sent, %0d results checked over %0d register settings",
                 words_sent, words_seen, settings_run);
        $display("     %0d coil steps, %0d timer reloads, %0d stops, %0d mismatches",
                 ticks_seen, reloads_seen, stops_seen, mismatches);
        if (mismatches == 0 && pending_drive.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
